[rtl/lbrf_pkg.sv]
// ----------------------------------------------------------------------------
// lbrf_pkg
// Shared types and constants of the locked byte ring FIFO.
// ----------------------------------------------------------------------------
package lbrf_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int BYTE_W        = 8;
   localparam int FUNC_W        = 3;

   // Capacity register value after reset.
   localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd255;

   // Return codes.
   localparam logic [BYTE_W-1:0] RC_FAIL         = 8'd0;
   localparam logic [BYTE_W-1:0] RC_OK           = 8'd1;
   localparam logic [BYTE_W-1:0] RC_ALREADY_OPEN = 8'd2;

   // Token value that marks the lock as open.
   localparam logic [BYTE_W-1:0] TOKEN_OPEN = 8'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FLUSH     = 3'd0,
      FUNC_RESERVE   = 3'd1,
      FUNC_BLIND_RES = 3'd2,
      FUNC_RELEASE   = 3'd3,
      FUNC_OVERWRITE = 3'd4,
      FUNC_PUSH      = 3'd5,
      FUNC_POP       = 3'd6
   } func_type;

endpackage

[rtl/lbrf_channels.sv]
// ----------------------------------------------------------------------------
// lbrf channels
// Valid/ready channels for the request and response sides of the FIFO.
// ----------------------------------------------------------------------------
interface lbrf_req_if;
   logic                          valid;
   logic                          ready;
   logic [lbrf_pkg::FUNC_W-1:0]   func;
   logic [lbrf_pkg::BYTE_W-1:0]   data_byte;
   logic [lbrf_pkg::BYTE_W-1:0]   owner_token;
   logic [lbrf_pkg::BYTE_W-1:0]   reserve_count;

   modport source (output valid, func, data_byte, owner_token, reserve_count, input ready);
   modport sink   (input valid, func, data_byte, owner_token, reserve_count, output ready);
endinterface

interface lbrf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lbrf_pkg::BYTE_W-1:0]   return_code;
   logic [lbrf_pkg::BYTE_W-1:0]   read_byte;

   modport source (output valid, return_code, read_byte, input ready);
   modport sink   (input valid, return_code, read_byte, output ready);
endinterface

[rtl/locked_byte_ring_fifo_unit.sv]
// ----------------------------------------------------------------------------
// locked_byte_ring_fifo_unit
// Circular byte FIFO with an owner-token lock on its push side.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Contents
//   req_port   in         func, data_byte, owner_token, reserve_count
//   rsp_port   out        return_code, read_byte (one per request)
//   csr_*      in         capacity write (enable, data)
//
// One request is taken per cycle while no response stalls; its response is
// valid the cycle after the transfer, set by the store's registered read port.
// Indices, fill count and lock state update in the transfer cycle, so a pop
// right after a write reads the written byte with no interlock.
// Reset is synchronous and needs no clearing pass over the store.
// A stalled response blocks new requests only while it is still waiting.
// ----------------------------------------------------------------------------
module locked_byte_ring_fifo_unit #(
   parameter int DEPTH = lbrf_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   lbrf_req_if.sink                    req_port,
   lbrf_rsp_if.source                  rsp_port,
   input  logic                        csr_wr_en,
   input  logic [lbrf_pkg::BYTE_W-1:0] csr_wr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [lbrf_pkg::BYTE_W:0] DEPTH_W = (lbrf_pkg::BYTE_W + 1)'(DEPTH);

   logic [7:0] cap_ff, wr_idx_ff, rd_idx_ff, fill_ff, holder_ff, remain_ff;
   logic [7:0] cap_in, wr_idx_in, rd_idx_in, fill_in, holder_in, remain_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rc_ff, rc_in;
   logic       pop_ff, pop_in;
   logic [7:0] rd_data_ff;

   logic [7:0] mem_store [DEPTH];
   logic       mem_we, mem_re;

   logic       accept;
   logic [7:0] eff_cap, free_slots, rem_dec;

   function automatic logic [7:0] advance(input logic [7:0] idx, input logic [7:0] ec);
      advance = (idx >= ec - 8'd1) ? 8'd0 : idx + 8'd1;
   endfunction

   assign accept         = req_port.valid && req_port.ready;
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      if (cap_ff == 8'd0) begin
         eff_cap = 8'd1;
      end else if ({1'b0, cap_ff} > DEPTH_W) begin
         eff_cap = DEPTH_W[7:0];
      end else begin
         eff_cap = cap_ff;
      end
      free_slots = (fill_ff < eff_cap) ? eff_cap - fill_ff : 8'd0;
      rem_dec    = (remain_ff != 8'd0) ? remain_ff - 8'd1 : 8'd0;
   end

   always_comb begin
      cap_in    = csr_wr_en ? csr_wr_data : cap_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      holder_in = holder_ff;
      remain_in = remain_ff;
      rc_in     = lbrf_pkg::RC_FAIL;
      pop_in    = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      if (accept) begin
         case (lbrf_pkg::func_type'(req_port.func))
            lbrf_pkg::FUNC_FLUSH: begin
               wr_idx_in = 8'd0;
               rd_idx_in = 8'd0;
               fill_in   = 8'd0;
               holder_in = lbrf_pkg::TOKEN_OPEN;
               remain_in = 8'd0;
               rc_in     = lbrf_pkg::RC_OK;
            end
            lbrf_pkg::FUNC_RESERVE: begin
               if (holder_ff == lbrf_pkg::TOKEN_OPEN && free_slots >= req_port.reserve_count) begin
                  holder_in = req_port.owner_token;
                  remain_in = req_port.reserve_count;
                  rc_in     = lbrf_pkg::RC_OK;
               end
            end
            lbrf_pkg::FUNC_BLIND_RES: begin
               if (holder_ff == lbrf_pkg::TOKEN_OPEN && free_slots != 8'd0) begin
                  holder_in = req_port.owner_token;
                  remain_in = free_slots;
                  rc_in     = free_slots;
               end
            end
            lbrf_pkg::FUNC_RELEASE: begin
               if (holder_ff == req_port.owner_token) begin
                  holder_in = lbrf_pkg::TOKEN_OPEN;
                  remain_in = 8'd0;
                  rc_in     = lbrf_pkg::RC_OK;
               end else if (holder_ff == lbrf_pkg::TOKEN_OPEN) begin
                  rc_in = lbrf_pkg::RC_ALREADY_OPEN;
               end
            end
            lbrf_pkg::FUNC_OVERWRITE: begin
               // When full, the oldest byte is dropped and the count holds.
               if (free_slots == 8'd0) begin
                  rd_idx_in = advance(rd_idx_ff, eff_cap);
               end else begin
                  fill_in = fill_ff + 8'd1;
               end
               mem_we    = 1'b1;
               wr_idx_in = advance(wr_idx_ff, eff_cap);
               rc_in     = lbrf_pkg::RC_OK;
            end
            lbrf_pkg::FUNC_PUSH: begin
               if (holder_ff == req_port.owner_token && free_slots != 8'd0) begin
                  mem_we    = 1'b1;
                  wr_idx_in = advance(wr_idx_ff, eff_cap);
                  fill_in   = fill_ff + 8'd1;
                  rc_in     = lbrf_pkg::RC_OK;
                  // Open-lock pushes leave the reservation untouched.
                  if (req_port.owner_token != lbrf_pkg::TOKEN_OPEN) begin
                     remain_in = rem_dec;
                     if (rem_dec == 8'd0) begin
                        holder_in = lbrf_pkg::TOKEN_OPEN;
                     end
                  end
               end
            end
            lbrf_pkg::FUNC_POP: begin
               if (fill_ff != 8'd0) begin
                  mem_re    = 1'b1;
                  pop_in    = 1'b1;
                  rd_idx_in = advance(rd_idx_ff, eff_cap);
                  fill_in   = fill_ff - 8'd1;
                  rc_in     = lbrf_pkg::RC_OK;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lbrf_pkg::CAPACITY_RESET;
         wr_idx_ff    <= 8'd0;
         rd_idx_ff    <= 8'd0;
         fill_ff      <= 8'd0;
         holder_ff    <= lbrf_pkg::TOKEN_OPEN;
         remain_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         fill_ff      <= fill_in;
         holder_ff    <= holder_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rc_ff  <= rc_in;
         pop_ff <= pop_in;
      end
   end

   // Indices never reach DEPTH, as the effective capacity never exceeds it, so
   // the low address bits select the entry directly.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_store[wr_idx_ff[AW-1:0]] <= req_port.data_byte;
      end
   end

   // The read data register also serves as the response byte; it holds while
   // the response is stalled because no new pop is taken then.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem_store[rd_idx_ff[AW-1:0]];
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.return_code = rc_ff;
   assign rsp_port.read_byte   = pop_ff ? rd_data_ff : 8'd0;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, wr_idx_ff} < DEPTH_W) && ({1'b0, rd_idx_ff} < DEPTH_W))
      else $error("FIFO index outside the store");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.func == lbrf_pkg::FUNC_FLUSH
      |=> fill_ff == 8'd0 && holder_ff == lbrf_pkg::TOKEN_OPEN && remain_ff == 8'd0)
      else $error("flush did not clear the FIFO state");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.func == lbrf_pkg::FUNC_POP && fill_ff != 8'd0
      |=> fill_ff == $past(fill_ff) - 8'd1 && rsp_port.return_code == lbrf_pkg::RC_OK)
      else $error("taken pop did not count down the fill level");

   a_byte_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.read_byte != 8'd0 |-> rsp_port.return_code == lbrf_pkg::RC_OK)
      else $error("read byte returned without a successful pop");
`endif

endmodule

[tb/sv/lbrf_fifo_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbrf_fifo_checker
// Watches the request, response and capacity ports of the locked byte ring
// FIFO. It keeps its own copy of the ring, the lock and the capacity, works
// out the reply to every request transfer and compares each response
// transfer with the oldest reply still waiting.
// ----------------------------------------------------------------------------
module lbrf_fifo_checker (
   input  logic                        clock,
   input  logic                        reset,
   lbrf_req_if                         req_seen,
   lbrf_rsp_if                         rsp_seen,
   input  logic                        csr_wr_en,
   input  logic [lbrf_pkg::BYTE_W-1:0] csr_wr_data,
   output int                          fail_count,
   output int                          replies_pending
);

   typedef struct packed {
      logic [lbrf_pkg::FUNC_W-1:0] op;
      logic [lbrf_pkg::BYTE_W-1:0] return_code;
      logic [lbrf_pkg::BYTE_W-1:0] read_byte;
   } fifo_reply_type;

   logic [lbrf_pkg::BYTE_W-1:0] byte_mem [0:lbrf_pkg::DEPTH_DEFAULT-1];
   logic [lbrf_pkg::BYTE_W-1:0] capacity_q;
   logic [lbrf_pkg::BYTE_W-1:0] wr_ptr;
   logic [lbrf_pkg::BYTE_W-1:0] rd_ptr;
   logic [lbrf_pkg::BYTE_W-1:0] fill_level;
   logic [lbrf_pkg::BYTE_W-1:0] lock_owner;
   logic [lbrf_pkg::BYTE_W-1:0] lock_left;
   fifo_reply_type              awaited_replies [$];
   int                          mismatches;

   // A capacity of zero behaves as a single slot.
   function automatic int unsigned active_slots();
      return (capacity_q == 8'd0) ? 1 : int'(capacity_q);
   endfunction

   function automatic int unsigned free_slots();
      return (fill_level < active_slots()) ? active_slots() - fill_level : 0;
   endfunction

   // Indices left above the ring after a shrink wrap to zero on their next step.
   function automatic logic [lbrf_pkg::BYTE_W-1:0] step_index(
      input logic [lbrf_pkg::BYTE_W-1:0] idx
   );
      return (idx >= active_slots() - 1) ? '0 : idx + 8'd1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] lbrf check: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic apply_request(
      input  logic [lbrf_pkg::FUNC_W-1:0] op,
      input  logic [lbrf_pkg::BYTE_W-1:0] data,
      input  logic [lbrf_pkg::BYTE_W-1:0] token,
      input  logic [lbrf_pkg::BYTE_W-1:0] count,
      output fifo_reply_type              reply
   );
      int unsigned room;
      room  = free_slots();
      reply = '{op: op, return_code: lbrf_pkg::RC_FAIL, read_byte: '0};
      case (op)
         lbrf_pkg::FUNC_FLUSH: begin
            wr_ptr            = '0;
            rd_ptr            = '0;
            fill_level        = '0;
            lock_owner        = lbrf_pkg::TOKEN_OPEN;
            lock_left         = '0;
            reply.return_code = lbrf_pkg::RC_OK;
         end
         lbrf_pkg::FUNC_RESERVE: begin
            // Token zero leaves the lock open but still loads the count.
            if (lock_owner == lbrf_pkg::TOKEN_OPEN && room >= count) begin
               lock_owner        = token;
               lock_left         = count;
               reply.return_code = lbrf_pkg::RC_OK;
            end
         end
         lbrf_pkg::FUNC_BLIND_RES: begin
            if (lock_owner == lbrf_pkg::TOKEN_OPEN && room > 0) begin
               lock_owner        = token;
               lock_left         = 8'(room);
               reply.return_code = 8'(room);
            end
         end
         lbrf_pkg::FUNC_RELEASE: begin
            if (lock_owner == token) begin
               lock_owner        = lbrf_pkg::TOKEN_OPEN;
               lock_left         = '0;
               reply.return_code = lbrf_pkg::RC_OK;
            end else if (lock_owner == lbrf_pkg::TOKEN_OPEN) begin
               reply.return_code = lbrf_pkg::RC_ALREADY_OPEN;
            end
         end
         lbrf_pkg::FUNC_OVERWRITE: begin
            if (room == 0) begin
               rd_ptr = step_index(rd_ptr);
            end else begin
               fill_level = fill_level + 8'd1;
            end
            byte_mem[wr_ptr]  = data;
            wr_ptr            = step_index(wr_ptr);
            reply.return_code = lbrf_pkg::RC_OK;
         end
         lbrf_pkg::FUNC_PUSH: begin
            if (lock_owner == token && room > 0) begin
               byte_mem[wr_ptr] = data;
               wr_ptr           = step_index(wr_ptr);
               if (token != lbrf_pkg::TOKEN_OPEN) begin
                  if (lock_left > 0) lock_left = lock_left - 8'd1;
                  if (lock_left == 0) lock_owner = lbrf_pkg::TOKEN_OPEN;
               end
               fill_level        = fill_level + 8'd1;
               reply.return_code = lbrf_pkg::RC_OK;
            end
         end
         lbrf_pkg::FUNC_POP: begin
            if (fill_level > 0) begin
               reply.read_byte   = byte_mem[rd_ptr];
               rd_ptr            = step_index(rd_ptr);
               fill_level        = fill_level - 8'd1;
               reply.return_code = lbrf_pkg::RC_OK;
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      fifo_reply_type want;
      if (reset) begin
         capacity_q = lbrf_pkg::CAPACITY_RESET;
         wr_ptr     = '0;
         rd_ptr     = '0;
         fill_level = '0;
         lock_owner = lbrf_pkg::TOKEN_OPEN;
         lock_left  = '0;
         awaited_replies.delete();
      end else begin
         // A response always belongs to a request taken at an earlier edge.
         if (rsp_seen.valid && rsp_seen.ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch($sformatf("response rc=%0d byte=%0d with no request waiting",
                                         rsp_seen.return_code, rsp_seen.read_byte));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_seen.return_code !== want.return_code) begin
                  report_mismatch($sformatf("op %0d: return_code %0d, expected %0d", want.op,
                                            rsp_seen.return_code, want.return_code));
               end
               if (rsp_seen.read_byte !== want.read_byte) begin
                  report_mismatch($sformatf("op %0d: read_byte 0x%02h, expected 0x%02h", want.op,
                                            rsp_seen.read_byte, want.read_byte));
               end
            end
         end
         if (req_seen.valid && req_seen.ready) begin
            apply_request(req_seen.func, req_seen.data_byte, req_seen.owner_token,
                          req_seen.reserve_count, want);
            awaited_replies.push_back(want);
         end
         // A capacity write takes effect for requests after this edge.
         if (csr_wr_en) capacity_q = csr_wr_data;
      end
      replies_pending <= awaited_replies.size();
      fail_count      <= mismatches;
   end

endmodule

[tb/sv/tb_locked_byte_ring_fifo_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_locked_byte_ring_fifo_unit
// Drives the locked byte ring FIFO with a short directed run over the lock
// and full/empty corners, then random lock sessions, writes and pops across
// a series of capacities and idle patterns. A separate checker predicts
// every response; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_locked_byte_ring_fifo_unit;

   localparam real HALF_PERIOD     = 6.0;
   localparam int  RESET_CYCLES    = 6;
   localparam int  PHASE_COUNT     = 12;
   localparam int  ITEMS_PER_PHASE = 140;
   localparam int  CYCLE_LIMIT     = 500000;
   localparam int  SETTLE_CYCLES   = 4;

   // The selector value that no operation uses.
   localparam logic [lbrf_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   localparam logic [lbrf_pkg::BYTE_W-1:0] CAP_PLAN [PHASE_COUNT] = '{
      8'd1, 8'd0, 8'd255, 8'd2, 8'd5, 8'd254, 8'd17, 8'd3, 8'd64, 8'd255, 8'd128, 8'd0
   };

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [lbrf_pkg::BYTE_W-1:0] csr_wr_data;
   int                          send_idle_pct;
   int                          stall_pct;
   int                          cycle_count;
   int                          fail_count;
   int                          replies_pending;
   int                          cur_slots;

   lbrf_req_if req_if ();
   lbrf_rsp_if rsp_if ();

   locked_byte_ring_fifo_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lbrf_fifo_checker ring_check (
      .clock           (clock),
      .reset           (reset),
      .req_seen        (req_if),
      .rsp_seen        (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_locked_byte_ring_fifo_unit failed");
         $finish;
      end
   end

   function automatic int slots_of(input logic [lbrf_pkg::BYTE_W-1:0] value);
      return (value == 8'd0) ? 1 : int'(value);
   endfunction

   // Holds valid high from one transfer to the next unless an idle cycle is drawn.
   task automatic send_request(
      input logic [lbrf_pkg::FUNC_W-1:0] op,
      input logic [lbrf_pkg::BYTE_W-1:0] data,
      input logic [lbrf_pkg::BYTE_W-1:0] token,
      input logic [lbrf_pkg::BYTE_W-1:0] count
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= op;
      req_if.data_byte     <= data;
      req_if.owner_token   <= token;
      req_if.reserve_count <= count;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   task automatic write_capacity(input logic [lbrf_pkg::BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_mix(input int budget);
      int                          done;
      int                          kind;
      int                          n;
      int                          k;
      logic [lbrf_pkg::BYTE_W-1:0] tok;
      done = 0;
      while (done < budget) begin
         if ($urandom_range(39) == 0) wait_drained();
         kind = $urandom_range(99);
         tok  = 8'($urandom_range(1, 255));
         if (kind < 40) begin
            // Lock session: reserve, owner or stranger pushes, pops, maybe a release.
            if ($urandom_range(3) == 0) begin
               send_request(lbrf_pkg::FUNC_BLIND_RES, 8'($urandom), tok, 8'($urandom));
            end else begin
               send_request(lbrf_pkg::FUNC_RESERVE, 8'($urandom), tok,
                            ($urandom_range(7) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, (cur_slots < 12) ? cur_slots : 12)));
            end
            n = $urandom_range(0, 10);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(3) == 0) begin
                  send_request(lbrf_pkg::FUNC_POP, 8'($urandom), 8'($urandom), 8'($urandom));
               end else begin
                  send_request(lbrf_pkg::FUNC_PUSH, 8'($urandom),
                               ($urandom_range(5) == 0) ? 8'($urandom) : tok, 8'($urandom));
               end
            end
            done += n + 1;
            if ($urandom_range(1) == 0) begin
               send_request(lbrf_pkg::FUNC_RELEASE, 8'($urandom),
                            ($urandom_range(4) == 0) ? 8'($urandom) : tok, 8'($urandom));
               done++;
            end
         end else if (kind < 55) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               send_request(lbrf_pkg::FUNC_OVERWRITE, 8'($urandom), 8'($urandom),
                            8'($urandom));
            end
            done += n;
         end else if (kind < 75) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               send_request(lbrf_pkg::FUNC_POP, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            done += n;
         end else if (kind < 85) begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
               send_request(lbrf_pkg::FUNC_PUSH, 8'($urandom), lbrf_pkg::TOKEN_OPEN,
                            8'($urandom));
            end
            done += n;
         end else if (kind < 90) begin
            // Run past full so that the oldest bytes get dropped.
            n = cur_slots + $urandom_range(0, 2);
            for (k = 0; k < n; k++) begin
               send_request(lbrf_pkg::FUNC_OVERWRITE, 8'($urandom), 8'($urandom),
                            8'($urandom));
            end
            done += n;
         end else begin
            send_request(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
            done++;
         end
      end
   endtask

   initial begin : stimulus
      int                          phase;
      logic [lbrf_pkg::BYTE_W-1:0] next_cap;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_if.valid         = 1'b0;
      req_if.func          = lbrf_pkg::FUNC_FLUSH;
      req_if.data_byte     = '0;
      req_if.owner_token   = '0;
      req_if.reserve_count = '0;
      send_idle_pct        = 0;
      stall_pct            = 0;
      cur_slots            = slots_of(lbrf_pkg::CAPACITY_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Lock corners at the reset capacity.
      send_request(lbrf_pkg::FUNC_POP,       8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(lbrf_pkg::FUNC_RELEASE,   8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(lbrf_pkg::FUNC_RESERVE,   8'h00, 8'hFF,                8'hFF);
      send_request(lbrf_pkg::FUNC_RELEASE,   8'h00, 8'h05,                8'h00);
      send_request(lbrf_pkg::FUNC_PUSH,      8'h01, 8'h07,                8'h00);
      send_request(lbrf_pkg::FUNC_PUSH,      8'hFF, 8'hFF,                8'h00);
      send_request(lbrf_pkg::FUNC_BLIND_RES, 8'h00, 8'h11,                8'h00);
      send_request(lbrf_pkg::FUNC_RELEASE,   8'h00, 8'hFF,                8'h00);
      send_request(lbrf_pkg::FUNC_RELEASE,   8'h00, 8'h09,                8'h00);
      // A reservation of zero opens again on its first push.
      send_request(lbrf_pkg::FUNC_RESERVE,   8'h00, 8'h80,                8'h00);
      send_request(lbrf_pkg::FUNC_PUSH,      8'h00, 8'h80,                8'h00);
      send_request(lbrf_pkg::FUNC_RESERVE,   8'h00, lbrf_pkg::TOKEN_OPEN, 8'h0A);
      send_request(lbrf_pkg::FUNC_PUSH,      8'h5A, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(lbrf_pkg::FUNC_BLIND_RES, 8'h00, 8'h42,                8'h00);
      send_request(lbrf_pkg::FUNC_PUSH,      8'hA5, 8'h42,                8'h00);
      repeat (4) send_request(lbrf_pkg::FUNC_POP, 8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(FUNC_UNUSED,              8'hFF, 8'hFF,                8'hFF);
      send_request(lbrf_pkg::FUNC_FLUSH,     8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);

      // Full corners on a two-slot ring.
      wait_drained();
      write_capacity(8'd2);
      cur_slots = 2;
      send_request(lbrf_pkg::FUNC_OVERWRITE, 8'h11, 8'h00,                8'h00);
      send_request(lbrf_pkg::FUNC_OVERWRITE, 8'h22, 8'h00,                8'h00);
      send_request(lbrf_pkg::FUNC_OVERWRITE, 8'h33, 8'h00,                8'h00);
      send_request(lbrf_pkg::FUNC_PUSH,      8'h44, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(lbrf_pkg::FUNC_RESERVE,   8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);
      send_request(lbrf_pkg::FUNC_BLIND_RES, 8'h00, 8'h03,                8'h00);
      repeat (3) send_request(lbrf_pkg::FUNC_POP, 8'h00, lbrf_pkg::TOKEN_OPEN, 8'h00);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         next_cap = CAP_PLAN[phase];
         write_capacity(next_cap);
         // A grown ring would expose slots never written, so it starts empty.
         // A shrunk ring keeps its contents and stale indices.
         if (slots_of(next_cap) > cur_slots) begin
            send_request(lbrf_pkg::FUNC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
         end
         cur_slots = slots_of(next_cap);
         run_mix(ITEMS_PER_PHASE);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_locked_byte_ring_fifo_unit passed");
      end else begin
         $display("tb_locked_byte_ring_fifo_unit failed");
      end
      $finish;
   end

endmodule
